[sv/cry_pkg.sv]
// ----------------------------------------------------------------------------
// cry_pkg
// Shared types and constants for the camera ray generator pipeline.
// ----------------------------------------------------------------------------
package cry_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COL_X       = 3'd0;
  localparam logic [2:0] REG_COL_Y       = 3'd1;
  localparam logic [2:0] REG_COL_Z       = 3'd2;
  localparam logic [2:0] REG_TRANSLATION = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;
  localparam logic [2:0] REG_FOV         = 3'd5;
  localparam logic [2:0] REG_ASPECT      = 3'd6;
  localparam logic [2:0] REG_ORTHO       = 3'd7;

  // Stage counts of the pipeline sections.
  localparam int FRONT_LAT = 6;
  localparam int NORM_LAT  = 6;
  localparam int SQRT_LAT  = 31;
  localparam int DIV_LAT   = 18;
  localparam int PIPE_LAT  = FRONT_LAT + NORM_LAT + SQRT_LAT + DIV_LAT;

  typedef struct packed {
    logic [16:0] screen_u;
    logic [16:0] screen_v;
  } request_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [15:0] direction_z;
  } result_t;

  typedef struct packed {
    logic [47:0] col_x;
    logic [47:0] col_y;
    logic [47:0] col_z;
    logic [47:0] translation;
    logic        mode;
    logic [15:0] fov;
    logic [15:0] aspect;
    logic [31:0] ortho;
  } cfg_t;

  // Unnormalized world direction plus finished origin.
  typedef struct packed {
    logic [2:0][23:0] origin;
    logic [2:0][61:0] dir;
  } vec_t;

  // Values that ride along the square root and divider.
  typedef struct packed {
    logic [2:0][23:0] origin;
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [61:0] sum;
  } sq_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] len;
  } root_t;

endpackage

[sv/cry_front.sv]
// ----------------------------------------------------------------------------
// cry_front
// Camera-space vector, rotation into world space and ray origin.
// ----------------------------------------------------------------------------
module cry_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cry_pkg::request_t req,
  input  cry_pkg::cfg_t     cfg,
  output logic              out_valid,
  output cry_pkg::vec_t     out
);

  logic [5:0] vld;
  logic       ortho;

  logic signed [18:0] au, av;
  logic signed [16:0] k0, k1, asp;
  logic signed [35:0] p0, p1;
  logic signed [52:0] q0, q0r;
  logic signed [43:0] c1, cam0, cam1;
  logic signed [59:0] prod0 [3];
  logic signed [59:0] prod1 [3];
  logic signed [16:0] t3 [3];
  logic signed [61:0] sum [3];
  logic signed [61:0] rs [3];
  logic signed [23:0] org_sat [3];

  assign ortho = cfg.mode;
  assign au  = signed'({1'b0, req.screen_u, 1'b0}) - 19'sd65536;
  assign av  = signed'({1'b0, req.screen_v, 1'b0}) - 19'sd65536;
  assign k0  = signed'({1'b0, ortho ? cfg.ortho[15:0] : cfg.fov});
  assign k1  = signed'({1'b0, ortho ? cfg.ortho[31:16] : cfg.fov});
  assign asp = signed'({1'b0, cfg.aspect});
  // Round to nearest with ties away from zero, as a single add.
  assign q0r = q0 + 53'sd128 - signed'({52'd0, q0[52]});

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rs[r] = (sum[r] + 62'sd8388608 - signed'({61'd0, sum[r][61]})) >>> 24;
      if (rs[r] > 62'sd8388607) begin
        org_sat[r] = 24'sh7FFFFF;
      end else if (rs[r] < -62'sd8388608) begin
        org_sat[r] = -24'sd8388608;
      end else begin
        org_sat[r] = 24'(rs[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p0 <= au * k0;
    p1 <= av * k1;
    q0 <= ortho ? 53'(p0) : p0 * asp;
    c1 <= ortho ? -44'(p1) : -(44'(p1) <<< 8);
    cam0 <= ortho ? 44'(q0) : 44'(q0r >>> 8);
    cam1 <= c1;
    for (int r = 0; r < 3; r++) begin
      prod0[r] <= $signed(cfg.col_x[16*r +: 16]) * cam0;
      prod1[r] <= $signed(cfg.col_y[16*r +: 16]) * cam1;
      t3[r]    <= ortho ? 17'($signed(cfg.translation[16*r +: 16]))
                        : -17'($signed(cfg.col_z[16*r +: 16]));
      sum[r]   <= 62'(prod0[r]) + 62'(prod1[r]) + (62'(t3[r]) <<< 24);
      out.origin[r] <= ortho ? org_sat[r] : 24'($signed(cfg.translation[16*r +: 16]));
      out.dir[r]    <= ortho ? 62'(-17'($signed(cfg.col_z[16*r +: 16]))) : sum[r];
    end
  end

  assign out_valid = vld[5];

endmodule

[sv/cry_norm.sv]
// ----------------------------------------------------------------------------
// cry_norm
// Magnitudes, block scaling to a fixed exponent and sum of squares.
// ----------------------------------------------------------------------------
module cry_norm (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  cry_pkg::vec_t in,
  output logic          out_valid,
  output cry_pkg::sq_t  out
);

  logic [5:0] vld;
  logic [2:0][23:0] org [5];
  logic [2:0]       neg [5];
  logic [2:0][60:0] mag1, mag2, mag3;
  logic [60:0]      mx;
  logic [5:0]       lead, lead_c;
  logic             zero3, zero4, zero5;
  logic [2:0][29:0] m4, m5;
  logic [2:0][59:0] sq5;
  logic [5:0]       rsh, lsh;

  always_comb begin
    lead_c = '0;
    for (int b = 0; b < 61; b++) begin
      if (mx[b]) begin
        lead_c = 6'(b);
      end
    end
  end

  assign rsh = lead - 6'd29;
  assign lsh = 6'd29 - lead;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    org[0] <= in.origin;
    for (int k = 1; k < 5; k++) begin
      org[k] <= org[k-1];
      neg[k] <= neg[k-1];
    end
    for (int r = 0; r < 3; r++) begin
      neg[0][r] <= in.dir[r][61];
      mag1[r]   <= in.dir[r][61] ? 61'(-$signed(in.dir[r])) : in.dir[r][60:0];
      mag3[r]   <= mag2[r];
      if (lead >= 6'd29) begin
        m4[r] <= 30'(mag3[r] >> rsh);
      end else begin
        m4[r] <= 30'(mag3[r] << lsh);
      end
      m5[r]  <= m4[r];
      sq5[r] <= m4[r] * m4[r];
    end
    mag2 <= mag1;
    mx <= (mag1[0] >= mag1[1])
          ? ((mag1[0] >= mag1[2]) ? mag1[0] : mag1[2])
          : ((mag1[1] >= mag1[2]) ? mag1[1] : mag1[2]);
    lead  <= lead_c;
    zero3 <= (mx == '0);
    zero4 <= zero3;
    zero5 <= zero4;
    out.sum <= 62'(sq5[0]) + 62'(sq5[1]) + 62'(sq5[2]);
    out.side.origin <= org[4];
    out.side.neg    <= neg[4];
    out.side.mag    <= m5;
    out.side.zero   <= zero5;
  end

  assign out_valid = vld[5];

endmodule

[sv/cry_sqrt.sv]
// ----------------------------------------------------------------------------
// cry_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cry_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  cry_pkg::sq_t  in,
  output logic          out_valid,
  output cry_pkg::root_t out
);

  localparam int Steps = cry_pkg::SQRT_LAT;

  logic                vld  [Steps+1];
  logic [61:0]         rem  [Steps+1];
  logic [30:0]         root [Steps+1];
  cry_pkg::side_t      side [Steps+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in.sum;
  assign root[0] = '0;
  assign side[0] = in.side;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int I = Steps - 1 - k;
    logic [63:0] trial;
    logic        ge;

    // (root + 2^I)^2 - root^2, with root holding only bits above I.
    assign trial = ({33'd0, root[k]} << (I + 1)) | (64'd1 << (2 * I));
    assign ge    = {2'b00, rem[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? rem[k] - 62'(trial) : rem[k];
      root[k+1] <= ge ? (root[k] | (31'd1 << I)) : root[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[Steps];
  assign out.len   = root[Steps];
  assign out.side  = side[Steps];

endmodule

[sv/cry_div.sv]
// ----------------------------------------------------------------------------
// cry_div
// Three pipelined restoring dividers that scale each component to Q1.14.
// ----------------------------------------------------------------------------
module cry_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  cry_pkg::root_t  in,
  output logic            out_valid,
  output cry_pkg::result_t out
);

  localparam int QBits = 16;

  logic             vld [QBits+2];
  logic [2:0][46:0] rem [QBits+1];
  logic [2:0][15:0] quo [QBits+1];
  logic [30:0]      len [QBits+1];
  cry_pkg::side_t   side [QBits+1];
  logic [2:0][15:0] dir_c;
  logic [15:0]      qv [3];

  assign vld[0] = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else begin
      vld[1] <= vld[0];
    end
  end

  // Numerator with the half-divisor folded in for round to nearest.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rem[0][r] <= 47'({in.side.mag[r], 14'd0}) + 47'(in.len >> 1);
      quo[0][r] <= '0;
    end
    len[0]  <= in.len;
    side[0] <= in.side;
  end

  for (genvar k = 0; k < QBits; k++) begin : g_step
    localparam int I = QBits - 1 - k;
    logic [46:0] dv;

    assign dv = 47'(len[k]) << I;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+2] <= 1'b0;
      end else begin
        vld[k+2] <= vld[k+1];
      end
    end

    always_ff @(posedge clk) begin
      for (int r = 0; r < 3; r++) begin
        if (rem[k][r] >= dv) begin
          rem[k+1][r] <= rem[k][r] - dv;
          quo[k+1][r] <= quo[k][r] | (16'd1 << I);
        end else begin
          rem[k+1][r] <= rem[k][r];
          quo[k+1][r] <= quo[k][r];
        end
      end
      len[k+1]  <= len[k];
      side[k+1] <= side[k];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      qv[r] = (quo[QBits][r] > 16'd16384) ? 16'd16384 : quo[QBits][r];
      if (side[QBits].zero) begin
        dir_c[r] = '0;
      end else begin
        dir_c[r] = side[QBits].neg[r] ? -qv[r] : qv[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[QBits+1];
    end
  end

  always_ff @(posedge clk) begin
    out.origin_x    <= side[QBits].origin[0];
    out.origin_y    <= side[QBits].origin[1];
    out.origin_z    <= side[QBits].origin[2];
    out.direction_x <= dir_c[0];
    out.direction_y <= dir_c[1];
    out.direction_z <= dir_c[2];
  end

endmodule

[sv/camera_ray_generator.sv]
// ----------------------------------------------------------------------------
// camera_ray_generator
// Pinhole and orthographic camera ray generation in fixed point.
// ----------------------------------------------------------------------------
// Each request is accepted when start is high (busy is always low, so a new
// screen position may be issued every clock cycle) and its ray appears on
// result once it has passed through every pipeline stage, marked by done for a single
// cycle. The result cannot be held off: a receiver must take it in that
// cycle. The pipeline is made of these stages: six stages build the
// camera vector and rotate it, six more scale the direction and form its
// squared length, the square root takes one stage per result bit (31), and
// the three dividers take one stage per quotient bit plus an entry and an
// exit stage (18). Throughput is one ray per cycle. Results leave in the
// order the requests came in. Configuration registers are 64-bit words at
// byte address 8*index and must be written only while no request is in
// flight.
// ----------------------------------------------------------------------------
module camera_ray_generator (
  input  logic              clk,
  input  logic              rst,
  // Request channel
  input  logic              start,
  output logic              busy,
  input  cry_pkg::request_t request,
  // Result channel
  output logic              done,
  output cry_pkg::result_t  result,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [47:0] col_x, col_y, col_z, translation;
  logic        mode;
  logic [15:0] fov, aspect;
  logic [31:0] ortho;
  logic [2:0]  reg_idx;

  cry_pkg::cfg_t  cfg;
  cry_pkg::vec_t  vec;
  cry_pkg::sq_t   sq;
  cry_pkg::root_t root;
  logic           vec_valid, sq_valid, root_valid;

  // The pipeline never stalls, so a request can always be taken.
  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  // Register file. Writes complete in the access phase of the bus.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_x       <= 48'd16777216;
      col_y       <= 48'd256;
      col_z       <= 48'd1;
      translation <= 48'd0;
      mode        <= 1'b0;
      fov         <= 16'd256;
      aspect      <= 16'd256;
      ortho       <= 32'd16777472;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        cry_pkg::REG_COL_X:       col_x       <= pwdata[47:0];
        cry_pkg::REG_COL_Y:       col_y       <= pwdata[47:0];
        cry_pkg::REG_COL_Z:       col_z       <= pwdata[47:0];
        cry_pkg::REG_TRANSLATION: translation <= pwdata[47:0];
        cry_pkg::REG_MODE:        mode        <= pwdata[0];
        cry_pkg::REG_FOV:         fov         <= pwdata[15:0];
        cry_pkg::REG_ASPECT:      aspect      <= pwdata[15:0];
        cry_pkg::REG_ORTHO:       ortho       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cry_pkg::REG_COL_X:       prdata = 64'(col_x);
      cry_pkg::REG_COL_Y:       prdata = 64'(col_y);
      cry_pkg::REG_COL_Z:       prdata = 64'(col_z);
      cry_pkg::REG_TRANSLATION: prdata = 64'(translation);
      cry_pkg::REG_MODE:        prdata = 64'(mode);
      cry_pkg::REG_FOV:         prdata = 64'(fov);
      cry_pkg::REG_ASPECT:      prdata = 64'(aspect);
      cry_pkg::REG_ORTHO:       prdata = 64'(ortho);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.col_x       = col_x;
  assign cfg.col_y       = col_y;
  assign cfg.col_z       = col_z;
  assign cfg.translation = translation;
  assign cfg.mode        = mode;
  assign cfg.fov         = fov;
  assign cfg.aspect      = aspect;
  assign cfg.ortho       = ortho;

  // Camera vector, rotation and origin.
  cry_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .req       (request),
    .cfg       (cfg),
    .out_valid (vec_valid),
    .out       (vec)
  );

  // Scale the direction so its largest component has a fixed exponent.
  cry_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_valid),
    .in        (vec),
    .out_valid (sq_valid),
    .out       (sq)
  );

  // Length of the scaled direction.
  cry_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in        (sq),
    .out_valid (root_valid),
    .out       (root)
  );

  // Divide each component by the length and round to Q1.14.
  cry_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .in        (root),
    .out_valid (done),
    .out       (result)
  );

  // Every accepted request comes out after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(cry_pkg::PIPE_LAT) done)
    else $error("request did not complete after the pipeline latency");

  // No result without a request the pipeline latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, cry_pkg::PIPE_LAT))
    else $error("result without a matching request");

  // A unit direction never leaves the Q1.14 range of plus or minus one.
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.direction_x <= 16'sd16384 && result.direction_x >= -16'sd16384 &&
              result.direction_y <= 16'sd16384 && result.direction_y >= -16'sd16384 &&
              result.direction_z <= 16'sd16384 && result.direction_z >= -16'sd16384))
    else $error("direction component out of range");

endmodule
